// File: src/two_level_page_table_engine_macros.svh
// Assertion macros for the checker file.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_MACROS_SVH

// Checked at every edge outside reset.
`define TLPT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TLPT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/tlpt_pkg.sv
// Types, constants and helpers for the two-level page table engine.
package tlpt_pkg;

  localparam int MAX_TABLES_DEF = 64;
  localparam int TABLE_ENTRIES  = 1024;
  localparam int DIR_ENTRIES    = 1024;
  localparam int IDX_W          = 10;
  localparam int OFF_W          = 12;
  localparam int VA_W           = 32;
  localparam int FLAG_W         = 12;
  localparam int FRAME_W        = VA_W - OFF_W;

  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_XLATE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_NO_SLOT    = 2'd2;

  function automatic int slot_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  typedef struct packed {
    logic [1:0]        action;
    logic [VA_W-1:0]   virt_addr;
    logic [VA_W-1:0]   phys_addr;
    logic [FLAG_W-1:0] entry_flags;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [VA_W-1:0] translated;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_NEW,
    S_ENTRY
  } state_t;

  typedef struct packed {
    logic       clr_last;
    logic       present;
    logic       full;
    logic       ent_ok;
    logic [1:0] action;
  } walk_flags_t;

  typedef struct packed {
    logic       clr;
    logic       capture;
    logic       alloc;
    logic       ent_rd;
    logic       ent_wr;
    logic       fresh;
    logic       done;
    logic       hit;
    logic [1:0] status;
  } walk_ctrl_t;

endpackage

// File: src/tlpt_ram.sv
// Generic simple dual-port RAM with registered read.
module tlpt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/tlpt_ctrl.sv
// Walk sequencer: directory clear, directory lookup, table allocation, entry access.
module tlpt_ctrl import tlpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  walk_flags_t flags,
  output walk_ctrl_t  ctl,
  output logic        busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (flags.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        state_next = S_IDLE;
        case (flags.action)
          ACT_MAP: begin
            if (flags.present) begin
              state_next = S_ENTRY;
            end else if (!flags.full) begin
              state_next = S_NEW;
            end
          end
          ACT_UNMAP, ACT_XLATE: begin
            if (flags.present) begin
              state_next = S_ENTRY;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_NEW:   state_next = S_IDLE;
      S_ENTRY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state)
      S_CLEAR: ctl.clr = 1'b1;
      S_IDLE: begin
        busy        = 1'b0;
        ctl.capture = start;
      end
      S_DIR: begin
        case (flags.action)
          ACT_MAP: begin
            if (flags.present) begin
              ctl.ent_rd = 1'b1;
            end else if (flags.full) begin
              ctl.done   = 1'b1;
              ctl.status = ST_NO_SLOT;
            end else begin
              ctl.alloc = 1'b1;
            end
          end
          ACT_UNMAP, ACT_XLATE: begin
            if (flags.present) begin
              ctl.ent_rd = 1'b1;
            end else begin
              ctl.done   = 1'b1;
              ctl.status = ST_NOT_MAPPED;
            end
          end
          default: begin
            ctl.done   = 1'b1;
            ctl.status = ST_OK;
          end
        endcase
      end
      S_NEW: begin
        ctl.ent_wr = 1'b1;
        ctl.fresh  = 1'b1;
        ctl.done   = 1'b1;
        ctl.status = ST_OK;
      end
      S_ENTRY: begin
        ctl.done = 1'b1;
        if (flags.action == ACT_XLATE) begin
          ctl.hit    = flags.ent_ok;
          ctl.status = flags.ent_ok ? ST_OK : ST_NOT_MAPPED;
        end else begin
          ctl.ent_wr = 1'b1;
          ctl.status = ST_OK;
        end
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: src/two_level_page_table_engine.sv
// Top level: two-level page table engine with map, unmap and translate.
//
// After reset the engine holds busy while it clears the page directory, one
// slot a cycle. An item is then taken when start is high and busy is low. A
// refused map, an unmap or translate on an absent directory slot, and the
// unused action code finish in S_DIR after the directory RAM read; a map that
// takes a new table goes on to S_NEW to write it, and every other item goes
// on to S_ENTRY for the dependent entry-valid and table RAM read. No item is
// taken while busy. The result is on the ports in the first cycle that busy
// is low, marked by done for exactly one cycle. The result cannot be held
// off: sample it when done is high. A map to an absent slot takes the next of
// MAX_TABLES tables; once all are handed out, such maps return status 2.
module two_level_page_table_engine import tlpt_pkg::*; #(
  parameter int MAX_TABLES = MAX_TABLES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int SLOT_W = slot_width(MAX_TABLES);
  localparam int CNT_W  = $clog2(MAX_TABLES + 1);
  localparam int DIR_W  = SLOT_W + 1;
  localparam int TBL_AW = SLOT_W + IDX_W;

  walk_flags_t flags;
  walk_ctrl_t  ctl;

  cmd_t               cmd_q;
  logic [SLOT_W-1:0]  slot;
  logic [CNT_W-1:0]   next_table_slot;
  logic [IDX_W-1:0]   clr_cnt;

  logic [IDX_W-1:0]         dix;
  logic [IDX_W-1:0]         tix;
  logic [DIR_W-1:0]         dir_wdata;
  logic [IDX_W-1:0]         dir_waddr;
  logic [DIR_W-1:0]         dir_rdata;
  logic [SLOT_W-1:0]        dir_slot;
  logic [TABLE_ENTRIES-1:0] row_rdata;
  logic [TABLE_ENTRIES-1:0] row_wdata;
  logic [TABLE_ENTRIES-1:0] row_bit;
  logic [VA_W-1:0]          tbl_rdata;
  logic [VA_W-1:0]          tbl_wdata;

  assign dix      = cmd_q.virt_addr[VA_W-1 -: IDX_W];
  assign tix      = cmd_q.virt_addr[OFF_W +: IDX_W];
  assign dir_slot = dir_rdata[SLOT_W-1:0];
  assign row_bit  = TABLE_ENTRIES'(1) << tix;

  assign dir_waddr = ctl.clr ? clr_cnt : dix;
  assign dir_wdata = ctl.clr ? '0 : {1'b1, next_table_slot[SLOT_W-1:0]};
  assign row_wdata = ctl.fresh ? row_bit : (row_rdata | row_bit);
  assign tbl_wdata = (cmd_q.action == ACT_MAP)
                   ? {cmd_q.phys_addr[VA_W-1:OFF_W], cmd_q.entry_flags}
                   : '0;

  assign flags.clr_last = (clr_cnt == IDX_W'(DIR_ENTRIES - 1));
  assign flags.present  = dir_rdata[SLOT_W];
  assign flags.full     = (next_table_slot >= CNT_W'(MAX_TABLES));
  assign flags.ent_ok   = row_rdata[tix] & tbl_rdata[0];
  assign flags.action   = cmd_q.action;

  tlpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  tlpt_ram #(
    .WIDTH  (DIR_W),
    .DEPTH  (DIR_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_dir_ram (
    .clk   (clk),
    .we    (ctl.clr | ctl.alloc),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (ctl.capture),
    .raddr (cmd.virt_addr[VA_W-1 -: IDX_W]),
    .rdata (dir_rdata)
  );

  tlpt_ram #(
    .WIDTH  (TABLE_ENTRIES),
    .DEPTH  (MAX_TABLES),
    .ADDR_W (SLOT_W)
  ) u_valid_ram (
    .clk   (clk),
    .we    (ctl.ent_wr),
    .waddr (slot),
    .wdata (row_wdata),
    .re    (ctl.ent_rd),
    .raddr (dir_slot),
    .rdata (row_rdata)
  );

  tlpt_ram #(
    .WIDTH  (VA_W),
    .DEPTH  (MAX_TABLES * TABLE_ENTRIES),
    .ADDR_W (TBL_AW)
  ) u_table_ram (
    .clk   (clk),
    .we    (ctl.ent_wr),
    .waddr ({slot, tix}),
    .wdata (tbl_wdata),
    .re    (ctl.ent_rd),
    .raddr ({dir_slot, tix}),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      next_table_slot <= '0;
      clr_cnt         <= '0;
      done            <= 1'b0;
    end else begin
      if (ctl.clr) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (ctl.alloc) begin
        next_table_slot <= next_table_slot + CNT_W'(1);
      end
      done <= ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= cmd;
    end
    if (ctl.alloc) begin
      slot <= next_table_slot[SLOT_W-1:0];
    end else if (ctl.ent_rd) begin
      slot <= dir_slot;
    end
    if (ctl.done) begin
      result.status     <= ctl.status;
      result.translated <= ctl.hit
                         ? {tbl_rdata[VA_W-1:OFF_W], cmd_q.virt_addr[OFF_W-1:0]}
                         : '0;
    end
  end

endmodule

// File: src/tlpt_checker.sv
// Port-level checks for the page table engine, bound to the top level.
`include "two_level_page_table_engine_macros.svh"

module tlpt_checker import tlpt_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  `TLPT_ASSERT_ALWAYS(a_busy_after_rst, rst |=> busy, "not busy after reset")
  `TLPT_ASSERT(a_busy_after_take, (start && !busy) |=> busy, "word taken but not busy")
  `TLPT_ASSERT(a_no_early_done, (start && !busy) |=> !done, "result on cycle after take")
  `TLPT_ASSERT(a_addr_only_ok, (done && result.translated != '0) |-> result.status == ST_OK, "address with failing status")

endmodule

bind two_level_page_table_engine tlpt_checker u_tlpt_checker (.*);
